FILE: rtl/fpd_pkg.sv
`timescale 1ns / 1ps

package fpd_pkg;

  localparam int unsigned MAX_DATA_BYTES = 4096;

  // Byte counter covers the payload length and the eight field bytes.
  localparam int unsigned CNT_W =
      ($clog2(MAX_DATA_BYTES + 1) > 4) ? $clog2(MAX_DATA_BYTES + 1) : 4;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HDR_W    = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned DLEN_W   = 13;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERMINAL = 1'd1;

  localparam logic [CNT_W-1:0] CMD_DONE    = CNT_W'(2);
  localparam logic [CNT_W-1:0] METHOD_DONE = CNT_W'(4);
  localparam logic [CNT_W-1:0] LENGTH_DONE = CNT_W'(8);
  localparam logic [CNT_W-1:0] WORD_DONE   = CNT_W'(4);

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] NUL_CHAR   = 8'h00;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT0   = 3'd0,
    PH_HUNT1   = 3'd1,
    PH_FIELDS  = 3'd2,
    PH_DATA    = 3'd3,
    PH_TERM    = 3'd4,
    PH_SUM_OK  = 3'd5,
    PH_SUM_BAD = 3'd6
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_LEN_ALIGN = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_BAD_TERM = 3'd3,
    ST_BAD_SUM  = 3'd4
  } status_e;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [IDX_W-1:0]    byte_index;
    status_e             status;
    logic [HDR_W-1:0]    cmd;
    logic [HDR_W-1:0]    method;
    logic [DLEN_W-1:0]   data_length;
  } result_t;

endpackage

FILE: rtl/framed_packet_deframer.sv
`timescale 1ns / 1ps

// Byte-serial deframer for little-endian length-prefixed frames (header, cmd,
// method, length, payload, terminal, sum). It takes one byte per cycle and
// registers the result word, if any, of each accepted byte in the output
// register; a new byte is accepted whenever that register is empty or
// is being emptied in the same cycle. Each payload byte leaves as a data word,
// and the last sum byte of a frame, or a bad length field, yields one status
// word; after a complete frame that word carries the trimmed payload length,
// after a bad length field it carries zero. Register writes take effect at
// once and should be made while no frame is in progress.
module framed_packet_deframer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fpd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fpd_pkg::WORD_W-1:0]       cfg_wdata_i,
  input  logic                             rx_valid_i,
  output logic                             rx_ready_o,
  input  logic [fpd_pkg::BYTE_W-1:0]       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_kind_o,
  output logic [fpd_pkg::BYTE_W-1:0]       data_byte_o,
  output logic [fpd_pkg::IDX_W-1:0]        byte_index_o,
  output logic [fpd_pkg::STATUS_W-1:0]     frame_status_o,
  output logic [fpd_pkg::HDR_W-1:0]        cmd_value_o,
  output logic [fpd_pkg::HDR_W-1:0]        method_value_o,
  output logic [fpd_pkg::DLEN_W-1:0]       data_length_o
);

  localparam int unsigned CW = fpd_pkg::CNT_W;

  logic [fpd_pkg::HDR_W-1:0]  header_q;
  logic [fpd_pkg::WORD_W-1:0] terminal_q;

  fpd_pkg::phase_e            phase_q, phase_d;
  logic [fpd_pkg::BYTE_W-1:0] prev_q, prev_d;
  logic [CW-1:0]              count_q, count_d;
  logic [fpd_pkg::HDR_W-1:0]  cmd_q, cmd_d;
  logic [fpd_pkg::HDR_W-1:0]  method_q, method_d;
  logic [CW-1:0]              len_q, len_d;
  logic [fpd_pkg::WORD_W-1:0] sum_q, sum_d;
  logic [fpd_pkg::WORD_W-1:0] shift_q, shift_d;
  logic [CW-1:0]              trim_q, trim_d;

  logic                       out_valid_q, out_valid_d;
  fpd_pkg::result_t           out_q, out_d;

  fpd_pkg::result_t           res;
  logic                       res_valid;
  logic                       rx_fire;
  logic [fpd_pkg::WORD_W-1:0] shift_new;
  logic [1:0]                 lane;
  logic [fpd_pkg::WORD_W-1:0] sum_add;
  logic [CW-1:0]              cnt_inc;

  assign rx_ready_o = !out_valid_q || out_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  assign shift_new = {rx_byte_i, shift_q[fpd_pkg::WORD_W-1:fpd_pkg::BYTE_W]};
  assign lane      = count_q[1:0] + 2'd2;
  assign sum_add   = sum_q + ({24'd0, rx_byte_i} << {lane, 3'b000});
  assign cnt_inc   = count_q + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= '0;
      terminal_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fpd_pkg::REG_HEADER:   header_q   <= cfg_wdata_i[fpd_pkg::HDR_W-1:0];
        fpd_pkg::REG_TERMINAL: terminal_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    prev_d    = prev_q;
    count_d   = count_q;
    cmd_d     = cmd_q;
    method_d  = method_q;
    len_d     = len_q;
    sum_d     = sum_q;
    shift_d   = shift_q;
    trim_d    = trim_q;
    res_valid = 1'b0;
    res       = '{kind: fpd_pkg::KIND_STATUS, data_byte: '0, byte_index: '0,
                  status: fpd_pkg::ST_OK, cmd: cmd_q, method: method_q,
                  data_length: '0};

    if (rx_fire) begin
      unique case (phase_q)
        fpd_pkg::PH_HUNT1: begin
          if ({rx_byte_i, prev_q} == header_q) begin
            phase_d  = fpd_pkg::PH_FIELDS;
            sum_d    = {16'd0, header_q};
            count_d  = '0;
            shift_d  = '0;
            trim_d   = '0;
            cmd_d    = '0;
            method_d = '0;
            len_d    = '0;
          end
          prev_d = rx_byte_i;
        end
        fpd_pkg::PH_FIELDS: begin
          sum_d   = sum_add;
          shift_d = shift_new;
          count_d = cnt_inc;
          if (cnt_inc == fpd_pkg::CMD_DONE) begin
            cmd_d = shift_new[31:16];
          end else if (cnt_inc == fpd_pkg::METHOD_DONE) begin
            method_d = shift_new[31:16];
          end else if (cnt_inc == fpd_pkg::LENGTH_DONE) begin
            if (shift_new[1:0] != 2'd0) begin
              res_valid = 1'b1;
              res.status = fpd_pkg::ST_LEN_ALIGN;
            end else if (shift_new > fpd_pkg::WORD_W'(fpd_pkg::MAX_DATA_BYTES)) begin
              res_valid = 1'b1;
              res.status = fpd_pkg::ST_TOO_LONG;
            end else begin
              len_d   = shift_new[CW-1:0];
              count_d = '0;
              shift_d = '0;
              phase_d = (shift_new == '0) ? fpd_pkg::PH_TERM : fpd_pkg::PH_DATA;
            end
          end
        end
        fpd_pkg::PH_DATA: begin
          sum_d          = sum_add;
          res_valid      = 1'b1;
          res.kind       = fpd_pkg::KIND_DATA;
          res.data_byte  = rx_byte_i;
          res.byte_index = fpd_pkg::IDX_W'(count_q);
          count_d        = cnt_inc;
          if (rx_byte_i != fpd_pkg::SPACE_CHAR && rx_byte_i != fpd_pkg::NUL_CHAR) begin
            trim_d = cnt_inc;
          end
          if (cnt_inc >= len_q) begin
            count_d = '0;
            shift_d = '0;
            phase_d = fpd_pkg::PH_TERM;
          end
        end
        fpd_pkg::PH_TERM: begin
          sum_d   = sum_add;
          shift_d = shift_new;
          count_d = cnt_inc;
          if (cnt_inc == fpd_pkg::WORD_DONE) begin
            phase_d = (shift_new == terminal_q) ? fpd_pkg::PH_SUM_OK : fpd_pkg::PH_SUM_BAD;
            count_d = '0;
            shift_d = '0;
          end
        end
        fpd_pkg::PH_SUM_OK, fpd_pkg::PH_SUM_BAD: begin
          shift_d = shift_new;
          count_d = cnt_inc;
          if (cnt_inc == fpd_pkg::WORD_DONE) begin
            res_valid       = 1'b1;
            res.data_length = fpd_pkg::DLEN_W'(trim_q);
            if (phase_q == fpd_pkg::PH_SUM_BAD) begin
              res.status = fpd_pkg::ST_BAD_TERM;
            end else if (shift_new != (32'd0 - sum_q)) begin
              res.status = fpd_pkg::ST_BAD_SUM;
            end
          end
        end
        default: begin
          prev_d  = rx_byte_i;
          phase_d = fpd_pkg::PH_HUNT1;
        end
      endcase

      if (res_valid && res.kind == fpd_pkg::KIND_STATUS) begin
        phase_d = fpd_pkg::PH_HUNT0;
        prev_d  = '0;
        count_d = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (rx_fire && res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fpd_pkg::PH_HUNT0;
      prev_q      <= '0;
      count_q     <= '0;
      cmd_q       <= '0;
      method_q    <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      shift_q     <= '0;
      trim_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      prev_q      <= prev_d;
      count_q     <= count_d;
      cmd_q       <= cmd_d;
      method_q    <= method_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      shift_q     <= shift_d;
      trim_q      <= trim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_q.kind;
  assign data_byte_o    = out_q.data_byte;
  assign byte_index_o   = out_q.byte_index;
  assign frame_status_o = out_q.status;
  assign cmd_value_o    = out_q.cmd;
  assign method_value_o = out_q.method;
  assign data_length_o  = out_q.data_length;

  a_status_rehunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && res_valid && res.kind == fpd_pkg::KIND_STATUS)
      |=> (phase_q == fpd_pkg::PH_HUNT0 && count_q == '0))
    else $error("status word did not return the deframer to hunting");

  a_data_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == fpd_pkg::KIND_DATA)
      |-> (out_q.status == fpd_pkg::ST_OK && out_q.data_length == '0))
    else $error("data word carries status or length");

  a_data_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == fpd_pkg::PH_DATA) |-> (count_q < len_q && trim_q <= count_q))
    else $error("payload counter out of range");

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending output word was lost or changed");

endmodule

FILE: dv/framed_packet_deframer_tb.sv
`timescale 1ns / 1ps

module framed_packet_deframer_tb;
  import fpd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int          LONG_STALL       = 300;
  localparam int          SHOWN_MISMATCHES = 10;

  typedef enum int {
    FLAW_NONE,
    FLAW_TERM,
    FLAW_SUM,
    FLAW_BOTH,
    FLAW_CUT
  } frame_flaw_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_HEADER;
  logic [WORD_W-1:0]    cfg_wdata_i = '0;
  logic                 rx_valid_i  = 1'b0;
  logic [BYTE_W-1:0]    rx_byte_i   = '0;
  logic                 out_ready_i = 1'b0;
  logic                 rx_ready_o;
  logic                 out_valid_o;
  logic                 out_kind_o;
  logic [BYTE_W-1:0]    data_byte_o;
  logic [IDX_W-1:0]     byte_index_o;
  logic [STATUS_W-1:0]  frame_status_o;
  logic [HDR_W-1:0]     cmd_value_o;
  logic [HDR_W-1:0]     method_value_o;
  logic [DLEN_W-1:0]    data_length_o;

  // Register mirror, shared by the frame builder and the deframing predictor.
  logic [HDR_W-1:0]  header_reg   = '0;
  logic [WORD_W-1:0] terminal_reg = '0;

  phase_e             sync_phase  = PH_HUNT0;
  logic [BYTE_W-1:0]  held_byte   = '0;
  logic [CNT_W-1:0]   pos_count   = '0;
  logic [HDR_W-1:0]   cmd_seen    = '0;
  logic [HDR_W-1:0]   method_seen = '0;
  logic [WORD_W-1:0]  length_seen = '0;
  logic [WORD_W-1:0]  word_sum    = '0;
  logic [WORD_W-1:0]  shift_word  = '0;
  logic [DLEN_W-1:0]  trimmed_len = '0;

  logic [BYTE_W-1:0] pending_bytes[$];
  result_t           expected_words[$];

  int          stim_bytes     = 0;
  int          mismatches     = 0;
  int          send_gap       = 0;
  int          recv_gap       = 0;
  int          stall_requests = 0;
  int          stalls_served  = 0;
  int unsigned quiet_cycles   = 0;
  bit          idling_on      = 1'b1;

  framed_packet_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_status_o (frame_status_o),
    .cmd_value_o    (cmd_value_o),
    .method_value_o (method_value_o),
    .data_length_o  (data_length_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic string word_text(input result_t w);
    return $sformatf("kind %0d byte %02h index %0d status %0d cmd %04h method %04h length %0d",
                     w.kind, w.data_byte, w.byte_index, w.status, w.cmd, w.method,
                     w.data_length);
  endfunction

  task automatic emit_status(input status_e st, input logic [DLEN_W-1:0] dlen);
    result_t w;
    w = '0;
    w.kind = KIND_STATUS;
    w.status = st;
    w.cmd = cmd_seen;
    w.method = method_seen;
    w.data_length = dlen;
    expected_words.insert(expected_words.size(), w);
    sync_phase = PH_HUNT0;
    held_byte = '0;
    pos_count = '0;
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    logic [1:0] lane;
    result_t    w;
    lane = pos_count[1:0] + 2'd2;
    case (sync_phase)
      PH_HUNT0: begin
        held_byte = b;
        sync_phase = PH_HUNT1;
      end
      PH_HUNT1: begin
        if ({b, held_byte} == header_reg) begin
          sync_phase = PH_FIELDS;
          word_sum = {16'h0000, header_reg};
          pos_count = '0;
          shift_word = '0;
          trimmed_len = '0;
          cmd_seen = '0;
          method_seen = '0;
          length_seen = '0;
        end
        held_byte = b;
      end
      PH_FIELDS: begin
        word_sum += 32'(b) << (8 * lane);
        shift_word = {b, shift_word[31:8]};
        pos_count++;
        if (pos_count == CMD_DONE) begin
          cmd_seen = shift_word[31:16];
        end else if (pos_count == METHOD_DONE) begin
          method_seen = shift_word[31:16];
        end else if (pos_count == LENGTH_DONE) begin
          length_seen = shift_word;
          if (length_seen[1:0] != 2'b00) begin
            emit_status(ST_LEN_ALIGN, '0);
          end else if (length_seen > MAX_DATA_BYTES) begin
            emit_status(ST_TOO_LONG, '0);
          end else begin
            pos_count = '0;
            shift_word = '0;
            sync_phase = (length_seen == 0) ? PH_TERM : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        word_sum += 32'(b) << (8 * lane);
        w = '0;
        w.kind = KIND_DATA;
        w.data_byte = b;
        w.byte_index = pos_count[IDX_W-1:0];
        w.status = ST_OK;
        w.cmd = cmd_seen;
        w.method = method_seen;
        expected_words.insert(expected_words.size(), w);
        pos_count++;
        if (b != SPACE_CHAR && b != NUL_CHAR) begin
          trimmed_len = DLEN_W'(pos_count);
        end
        if (32'(pos_count) >= length_seen) begin
          pos_count = '0;
          shift_word = '0;
          sync_phase = PH_TERM;
        end
      end
      PH_TERM: begin
        word_sum += 32'(b) << (8 * lane);
        shift_word = {b, shift_word[31:8]};
        pos_count++;
        if (pos_count == WORD_DONE) begin
          sync_phase = (shift_word == terminal_reg) ? PH_SUM_OK : PH_SUM_BAD;
          pos_count = '0;
          shift_word = '0;
        end
      end
      PH_SUM_OK, PH_SUM_BAD: begin
        shift_word = {b, shift_word[31:8]};
        pos_count++;
        if (pos_count == WORD_DONE) begin
          if (sync_phase == PH_SUM_BAD) begin
            emit_status(ST_BAD_TERM, trimmed_len);
          end else if (shift_word != 32'(0) - word_sum) begin
            emit_status(ST_BAD_SUM, trimmed_len);
          end else begin
            emit_status(ST_OK, trimmed_len);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
      rx_byte_i <= '0;
      send_gap <= 0;
    end else begin
      if (rx_valid_i && rx_ready_o) begin
        deframe_byte(rx_byte_i);
      end
      if (!rx_valid_i || rx_ready_o) begin
        if (send_gap != 0) begin
          rx_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (idling_on && pending_bytes.size() != 0 && $urandom_range(0, 7) == 0) begin
          rx_valid_i <= 1'b0;
          send_gap <= $urandom_range(0, 8);
        end else if (pending_bytes.size() != 0) begin
          rx_valid_i <= 1'b1;
          rx_byte_i <= pending_bytes.pop_front();
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
      stalls_served <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.kind = out_kind_o;
        got.data_byte = data_byte_o;
        got.byte_index = byte_index_o;
        got.status = status_e'(frame_status_o);
        got.cmd = cmd_value_o;
        got.method = method_value_o;
        got.data_length = data_length_o;
        if (expected_words.size() == 0) begin
          if (mismatches < SHOWN_MISMATCHES) begin
            $display("unexpected word: %s", word_text(got));
          end
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.byte_index !== want.byte_index || got.status !== want.status ||
              got.cmd !== want.cmd || got.method !== want.method ||
              got.data_length !== want.data_length) begin
            if (mismatches < SHOWN_MISMATCHES) begin
              $display("word mismatch\n  expected: %s\n  actual:   %s",
                       word_text(want), word_text(got));
            end
            mismatches++;
          end
        end
      end
      if (stalls_served != stall_requests) begin
        stalls_served <= stall_requests;
        recv_gap <= LONG_STALL - 1;
        out_ready_i <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("framed_packet_deframer verification failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
    stim_bytes++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_HEADER) begin
      header_reg = value[HDR_W-1:0];
    end else begin
      terminal_reg = value;
    end
    @(negedge clk_i);
  endtask

  task automatic pick_settings();
    write_reg(REG_HEADER, $urandom);
    write_reg(REG_TERMINAL, $urandom);
  endtask

  // Builds a frame with the current header and terminal, then applies the flaw.
  // Payload padding is a random mix of spaces and NULs; the byte before it is never padding.
  task automatic queue_frame(input logic [HDR_W-1:0] cmd, input logic [HDR_W-1:0] method,
                             input logic [WORD_W-1:0] len_field, input int pad,
                             input frame_flaw_e flaw);
    logic [BYTE_W-1:0] fb[$];
    logic [WORD_W-1:0] term;
    logic [WORD_W-1:0] frame_sum;
    int                body;
    int                keep;
    fb = {};
    fb.insert(fb.size(), header_reg[7:0]);
    fb.insert(fb.size(), header_reg[15:8]);
    fb.insert(fb.size(), cmd[7:0]);
    fb.insert(fb.size(), cmd[15:8]);
    fb.insert(fb.size(), method[7:0]);
    fb.insert(fb.size(), method[15:8]);
    for (int i = 0; i < 4; i++) begin
      fb.insert(fb.size(), len_field[8*i +: 8]);
    end
    if (len_field[1:0] == 2'b00 && len_field <= MAX_DATA_BYTES) begin
      body = int'(len_field) - pad;
      for (int i = 0; i < int'(len_field); i++) begin
        if (i >= body) begin
          fb.insert(fb.size(), $urandom_range(0, 1) ? SPACE_CHAR : NUL_CHAR);
        end else if (i == body - 1) begin
          fb.insert(fb.size(), 8'($urandom_range(33, 255)));
        end else begin
          fb.insert(fb.size(), 8'($urandom_range(0, 255)));
        end
      end
      term = terminal_reg;
      if (flaw == FLAW_TERM || flaw == FLAW_BOTH) begin
        term ^= 32'd1 << $urandom_range(0, 31);
      end
      for (int i = 0; i < 4; i++) begin
        fb.insert(fb.size(), term[8*i +: 8]);
      end
      frame_sum = '0;
      for (int i = 0; i < fb.size(); i++) begin
        frame_sum += 32'(fb[i]) << (8 * (i % 4));
      end
      frame_sum = 32'(0) - frame_sum;
      if (flaw == FLAW_SUM || flaw == FLAW_BOTH) begin
        frame_sum ^= 32'($urandom_range(32'hFFFF_FFFF, 1));
      end
      for (int i = 0; i < 4; i++) begin
        fb.insert(fb.size(), frame_sum[8*i +: 8]);
      end
    end
    keep = fb.size();
    if (flaw == FLAW_CUT) begin
      keep = $urandom_range(1, fb.size() - 1);
    end
    for (int i = 0; i < keep; i++) begin
      push_byte(fb[i]);
    end
  endtask

  task automatic run_traffic(input int budget);
    int start;
    int sel;
    int len;
    int pad;
    start = stim_bytes;
    while (stim_bytes - start < budget) begin
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? 4 * $urandom_range(9, 64) : 4 * $urandom_range(0, 8);
      pad = $urandom_range(0, (len < 6) ? len : 6);
      if (sel < 70) begin
        queue_frame(16'($urandom), 16'($urandom), len, pad, FLAW_NONE);
      end else if (sel < 76) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end else if (sel < 82) begin
        queue_frame(16'($urandom), 16'($urandom), len, pad, FLAW_TERM);
      end else if (sel < 88) begin
        queue_frame(16'($urandom), 16'($urandom), len, pad, FLAW_SUM);
      end else if (sel < 90) begin
        queue_frame(16'($urandom), 16'($urandom), len, pad, FLAW_BOTH);
      end else if (sel < 94) begin
        queue_frame(16'($urandom), 16'($urandom), len, pad, FLAW_CUT);
      end else if (sel < 97) begin
        queue_frame(16'($urandom), 16'($urandom),
                    32'($urandom) | 32'($urandom_range(1, 3)), 0, FLAW_NONE);
      end else begin
        queue_frame(16'($urandom), 16'($urandom),
                    $urandom_range(0, 1) ? 32'd4100 : ((32'($urandom) | 32'h1004) & ~32'h3),
                    0, FLAW_NONE);
      end
    end
  endtask

  // Lets the queued bytes go in, closes any open frame with NUL bytes, and
  // waits until every expected word has come out.
  task automatic settle();
    forever begin
      @(negedge clk_i);
      if (pending_bytes.size() == 0 && !rx_valid_i) begin
        if (sync_phase == PH_HUNT0 || sync_phase == PH_HUNT1) begin
          break;
        end
        push_byte(NUL_CHAR);
      end
    end
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_reg(REG_HEADER, {16'($urandom), 16'hFFFF});
    write_reg(REG_TERMINAL, 32'hFFFF_FFFF);
    push_byte(8'h00);
    push_byte(8'h80);
    push_byte(8'h7F);
    queue_frame(16'hFFFF, 16'h0000, 32'd0, 0, FLAW_NONE);
    queue_frame(16'h0000, 16'hFFFF, 32'd8, 3, FLAW_NONE);
    queue_frame(16'h1234, 16'h5678, 32'd8, 8, FLAW_NONE);
    queue_frame(16'h0001, 16'h0002, 32'd6, 0, FLAW_NONE);
    queue_frame(16'h0003, 16'h0004, 32'd4100, 0, FLAW_NONE);
    queue_frame(16'h0005, 16'h0006, 32'hFFFF_FFFF, 0, FLAW_NONE);
    queue_frame(16'h0007, 16'h0008, 32'd4, 0, FLAW_TERM);
    queue_frame(16'h0009, 16'h000A, 32'd4, 0, FLAW_SUM);
    queue_frame(16'h000B, 16'h000C, 32'd4, 1, FLAW_BOTH);
    settle();

    write_reg(REG_HEADER, 32'h0000_0000);
    write_reg(REG_TERMINAL, 32'h0000_0000);
    run_traffic(220);
    settle();

    pick_settings();
    run_traffic(220);
    stall_requests++;
    settle();

    pick_settings();
    queue_frame(16'h8001, 16'h7FFE, 32'd128, 0, FLAW_NONE);
    settle();

    pick_settings();
    run_traffic(220);
    settle();

    pick_settings();
    idling_on = 1'b0;
    run_traffic(260);
    settle();

    if (expected_words.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("framed_packet_deframer verification clean");
    end else begin
      $display("framed_packet_deframer verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fpd_pkg.sv
rtl/framed_packet_deframer.sv
dv/framed_packet_deframer_tb.sv
